@@ rtl/core/wlcc_pkg.sv @@
// Shared types and constants for the wrapped line and column counter.
package wlcc_pkg;

	localparam logic [1:0] OP_BREAK = 2'd0;
	localparam logic [1:0] OP_PLAIN = 2'd1;
	localparam logic [1:0] OP_WRAP  = 2'd2;
	localparam logic [1:0] OP_HEX   = 2'd3;

	localparam logic [1:0] REG_TEXT_W = 2'd0;
	localparam logic [1:0] REG_TAB_W  = 2'd1;
	localparam logic [1:0] REG_HEX_B  = 2'd2;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [10:0] TEXT_W_MAX = 11'd1024;
	localparam logic [6:0]  TAB_W_MAX  = 7'd64;
	localparam logic [8:0]  HEX_B_MAX  = 9'd256;

	localparam logic [10:0] TEXT_W_RST = 11'd80;
	localparam logic [6:0]  TAB_W_RST  = 7'd8;
	localparam logic [8:0]  HEX_B_RST  = 9'd16;

	localparam int DIV_W = 17;

	typedef struct packed {
		logic [10:0] text_w;
		logic [6:0]  tab_w;
		logic [8:0]  hex_b;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [8:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [8:0]       rem;
	} div_rsp_t;

endpackage

@@ rtl/core/wlcc_cfg.sv @@
// Configuration registers, clamped to their legal ranges on write.
module wlcc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	output wlcc_pkg::cfg_t      cfg
);

	logic [10:0] text_w_q;
	logic [6:0]  tab_w_q;
	logic [8:0]  hex_b_q;
	logic [10:0] text_w_d;
	logic [6:0]  tab_w_d;
	logic [8:0]  hex_b_d;

	always_comb begin
		text_w_d = cfg_data;
		if (cfg_data == 11'd0) begin
			text_w_d = 11'd1;
		end else if (cfg_data > wlcc_pkg::TEXT_W_MAX) begin
			text_w_d = wlcc_pkg::TEXT_W_MAX;
		end
		tab_w_d = cfg_data[6:0];
		if (cfg_data[6:0] == 7'd0) begin
			tab_w_d = 7'd1;
		end else if (cfg_data[6:0] > wlcc_pkg::TAB_W_MAX) begin
			tab_w_d = wlcc_pkg::TAB_W_MAX;
		end
		hex_b_d = cfg_data[8:0];
		if (cfg_data[8:0] == 9'd0) begin
			hex_b_d = 9'd1;
		end else if (cfg_data[8:0] > wlcc_pkg::HEX_B_MAX) begin
			hex_b_d = wlcc_pkg::HEX_B_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_w_q <= wlcc_pkg::TEXT_W_RST;
			tab_w_q  <= wlcc_pkg::TAB_W_RST;
			hex_b_q  <= wlcc_pkg::HEX_B_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wlcc_pkg::REG_TEXT_W: text_w_q <= text_w_d;
				wlcc_pkg::REG_TAB_W:  tab_w_q  <= tab_w_d;
				wlcc_pkg::REG_HEX_B:  hex_b_q  <= hex_b_d;
				default: ;
			endcase
		end
	end

	assign cfg.text_w = text_w_q;
	assign cfg.tab_w  = tab_w_q;
	assign cfg.hex_b  = hex_b_q;

endmodule

@@ rtl/core/wlcc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module wlcc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  wlcc_pkg::div_req_t  req,
	output wlcc_pkg::div_rsp_t  rsp
);

	localparam int W = wlcc_pkg::DIV_W;

	logic [W-1:0]         dq_q;
	logic [8:0]           r_q;
	logic [8:0]           d_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [9:0]           trial;
	logic                 fits;
	logic [9:0]           diff;

	assign trial = {r_q, dq_q[W-1]};
	assign fits  = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q <= req.dividend;
			d_q  <= req.divisor;
			r_q  <= '0;
		end else if (busy_q) begin
			dq_q <= {dq_q[W-2:0], fits};
			r_q  <= fits ? diff[8:0] : trial[8:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dq_q;
	assign rsp.rem  = r_q;

endmodule

@@ rtl/core/wrapped_line_column_counter.sv @@
// Top level: line and column counter with sequencer and shared divider.
// Tab words in wrap mode and non-empty hex chunk words pass through S_EXEC, S_DIV and S_FIN,
// using the 17-step bit-serial divider; all other words pass through S_EXEC and S_FIN.
// One word at a time, the next accepted only back in S_IDLE; a new word
// is accepted while a result waits at the output, and a held result stalls the next one.
// Reset: clears line count and column, loads widths 80, 8 and 16, drops output valid.
module wrapped_line_column_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  char_byte,
	input  logic [15:0] chunk_size,
	input  logic        last_of_part,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] line_total,
	output logic [10:0] column_now,
	output logic        part_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t              state_q;
	wlcc_pkg::cfg_t      cfg;
	wlcc_pkg::div_req_t  div_req;
	wlcc_pkg::div_rsp_t  div_rsp;

	logic [1:0]  op_q;
	logic [7:0]  ch_q;
	logic [15:0] size_q;
	logic        last_q;
	logic [31:0] line_q;
	logic [10:0] col_q;
	logic        out_valid_q;
	logic [31:0] line_total_q;
	logic [10:0] column_now_q;
	logic        part_done_q;

	logic        wrap_char;
	logic        at_end;
	logic        need_div;
	logic [16:0] add_n;
	logic [10:0] col_n;
	logic [32:0] sum;
	logic [31:0] line_n;
	logic [16:0] hex_t;
	logic [6:0]  step;
	logic [11:0] col_tab;
	logic        fin_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	wlcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wlcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign wrap_char = (op_q == wlcc_pkg::OP_WRAP) && (ch_q != wlcc_pkg::CH_CR)
		&& (ch_q != wlcc_pkg::CH_LF);
	assign at_end    = col_q >= cfg.text_w;
	assign need_div  = (wrap_char && (ch_q == wlcc_pkg::CH_TAB))
		|| ((op_q == wlcc_pkg::OP_HEX) && (size_q != 16'd0));
	assign hex_t     = {6'd0, col_q} + {1'b0, size_q} - 17'd1;
	assign step      = cfg.tab_w - div_rsp.rem[6:0];
	assign col_tab   = {1'b0, col_q} + {5'd0, step};
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		div_req.start    = (state_q == S_EXEC) && need_div;
		div_req.dividend = (op_q == wlcc_pkg::OP_HEX) ? hex_t
			: {6'd0, (at_end ? 11'd0 : col_q)};
		div_req.divisor  = (op_q == wlcc_pkg::OP_HEX) ? cfg.hex_b : {2'd0, cfg.tab_w};
	end

	always_comb begin
		add_n = '0;
		col_n = col_q;
		if (state_q == S_EXEC) begin
			if (wrap_char && at_end) begin
				add_n = 17'd1;
				col_n = '0;
			end
		end else if (state_q == S_FIN) begin
			case (op_q)
				wlcc_pkg::OP_BREAK: begin
					add_n = 17'd1;
					col_n = '0;
				end
				wlcc_pkg::OP_PLAIN: begin
					if (ch_q == wlcc_pkg::CH_LF) begin
						add_n = 17'd1;
					end
				end
				wlcc_pkg::OP_WRAP: begin
					if (ch_q == wlcc_pkg::CH_LF) begin
						add_n = 17'd1;
						col_n = '0;
					end else if (ch_q == wlcc_pkg::CH_TAB) begin
						col_n = (col_tab > {1'b0, cfg.text_w}) ? cfg.text_w : col_tab[10:0];
					end else if (ch_q != wlcc_pkg::CH_CR) begin
						col_n = col_q + 11'd1;
					end
				end
				default: begin
					if (size_q != 16'd0) begin
						add_n = div_rsp.quo;
						col_n = {2'd0, div_rsp.rem} + 11'd1;
					end
				end
			endcase
		end
		sum    = {1'b0, line_q} + {16'd0, add_n};
		line_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			line_q      <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					line_q  <= line_n;
					col_q   <= col_n;
					state_q <= need_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						line_q  <= line_n;
						col_q   <= col_n;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= opcode;
			ch_q   <= char_byte;
			size_q <= chunk_size;
			last_q <= last_of_part;
		end
		if (fin_fire) begin
			line_total_q <= line_n;
			column_now_q <= col_n;
			part_done_q  <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_total = line_total_q;
	assign column_now = column_now_q;
	assign part_done  = part_done_q;

endmodule
